// ----- hdl/cbe_pkg.sv -----
// Shared types, codes and constants of the cascaded biquad equalizer.
// Used by cbe_regs, cbe_mac and the top level; depends on nothing else.
package cbe_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int GAIN_BITS   = 24;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int PREAMP_FRAC = 20;
    localparam int PROD_W      = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + 3;
    localparam int SEL_W       = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Item modes.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_COEF   = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    // Coefficient selects; the bypass flag has its own slot in each band.
    localparam logic [SEL_W-1:0] SEL_A0     = 3'd0;
    localparam logic [SEL_W-1:0] SEL_A1     = 3'd1;
    localparam logic [SEL_W-1:0] SEL_A2     = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A3     = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A4     = 3'd4;
    localparam logic [SEL_W-1:0] SEL_BYPASS = 3'd5;

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_ACTIVE   = 2'd0;
    localparam logic [1:0] REG_BANDS    = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;
    localparam logic [1:0] REG_PREAMP   = 2'd3;

    localparam logic [GAIN_BITS-1:0] PREAMP_RESET = 24'd1048576;

    localparam logic signed [ACC_W:0] PRE_HALF =
        {{(ACC_W + 1 - PREAMP_FRAC){1'b0}}, 1'b1, {(PREAMP_FRAC - 1){1'b0}}};
    localparam logic signed [ACC_W:0] COEF_HALF =
        {{(ACC_W + 1 - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
    localparam logic signed [ACC_W:0] SAT_HI =
        {{(ACC_W + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [2:0]                    channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [4:0]                    band;
        logic [SEL_W-1:0]              coef_select;
        logic signed [COEF_BITS-1:0]   coef_value;
    } item_t;

    typedef struct packed {
        logic [2:0]                    out_channel;
        logic signed [SAMPLE_BITS-1:0] sample_out;
    } result_t;

    typedef struct packed {
        logic                 active;
        logic [5:0]           bands_in_use;
        logic [3:0]           channels_in_use;
        logic [GAIN_BITS-1:0] preamp_gain;
    } cfg_t;

    typedef struct packed {
        logic mul_en;
        logic clr;
        logic sub;
    } mac_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] y2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] x1;
    } hist_row_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRE_MUL,
        S_PRE_ACC,
        S_PRE_RND,
        S_BAND_RD,
        S_BAND_CHK,
        S_MAC,
        S_MAC_END,
        S_ROUND,
        S_WB,
        S_DONE
    } state_t;

    // Round half up, shift out the fraction and saturate to a sample.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] v,
        input logic                    pre
    );
        logic signed [ACC_W:0] s;
        logic signed [ACC_W:0] q;
        logic signed [SAMPLE_BITS-1:0] res;
        s = $signed({v[ACC_W-1], v}) + (pre ? PRE_HALF : COEF_HALF);
        q = pre ? (s >>> PREAMP_FRAC) : (s >>> COEF_FRAC);
        if (q > SAT_HI)
        begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (q < SAT_LO)
        begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            res = q[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hdl/cbe_regs.sv -----
// Configuration registers of the equalizer behind an APB-style port.
// Depends on cbe_pkg for the register indexes and the cfg_t struct.
module cbe_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cbe_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cbe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output cbe_pkg::cfg_t                      cfg
);
    import cbe_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active          <= 1'b0;
            cfg_reg.bands_in_use    <= '0;
            cfg_reg.channels_in_use <= '0;
            cfg_reg.preamp_gain     <= PREAMP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ACTIVE:   cfg_reg.active          <= pwdata[0];
                REG_BANDS:    cfg_reg.bands_in_use    <= pwdata[5:0];
                REG_CHANNELS: cfg_reg.channels_in_use <= pwdata[3:0];
                REG_PREAMP:   cfg_reg.preamp_gain     <= pwdata[GAIN_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACTIVE:   prdata = {31'd0, cfg_reg.active};
            REG_BANDS:    prdata = {26'd0, cfg_reg.bands_in_use};
            REG_CHANNELS: prdata = {28'd0, cfg_reg.channels_in_use};
            REG_PREAMP:   prdata = {{(APB_DATA_W - GAIN_BITS){1'b0}}, cfg_reg.preamp_gain};
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- hdl/cbe_mac.sv -----
// Shared multiply-accumulate unit: one registered product, then accumulate.
// Depends on cbe_pkg for widths and the mac_ctl_t control struct.
module cbe_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cbe_pkg::mac_ctl_t                     ctl,
    input  logic signed [cbe_pkg::COEF_BITS-1:0]  op_a,
    input  logic signed [cbe_pkg::SAMPLE_BITS-1:0] op_b,
    output logic signed [cbe_pkg::ACC_W-1:0]      acc
);
    import cbe_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     pend_reg;
    logic                     clr_reg;
    logic                     sub_reg;

    assign prod     = op_a * op_b;
    assign prod_ext = $signed({{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg});
    assign acc_base = clr_reg ? '0 : acc_reg;
    assign acc_next = sub_reg ? (acc_base - prod_ext) : (acc_base + prod_ext);
    assign acc      = acc_reg;

    // The product of one cycle is folded into the sum in the next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            clr_reg  <= 1'b0;
            sub_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.mul_en;
            if (ctl.mul_en)
            begin
                clr_reg <= ctl.clr;
                sub_reg <= ctl.sub;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod;
        end
        if (pend_reg)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- hdl/cascaded_biquad_equalizer.sv -----
// Top level of the cascaded biquad equalizer: sequencer, coefficient and
// history memories, output register. Depends on cbe_pkg, cbe_regs, cbe_mac.
//
//   Channel   Signals                              Width    Flow
//   config    psel penable pwrite paddr pwdata     4/32     write, read
//             prdata pready
//   item      item_valid item_stall item           69       in
//   result    result_valid result_stall result     27       out
//
// An equalized sample is scaled by the preamp gain and rounded, then passes each band
// in turn, filtered or bypassed, before it is loaded into the output register; the
// next item is taken after that. The single shared multiplier does the preamp
// product and five products per filtering section. Pass-through samples and
// coefficient writes are handled in idle. A flush item clears the history memory
// one row a cycle (2**(BW+CW) rows, 256 by default). After reset a clearing pass
// over 2**max(BW+CW, BW+3) addresses (256 by default) fills both memories;
// configuration writes are taken during it. item_stall is high while an item
// is in work or clearing, or while the output register is full and stalled.
module cascaded_biquad_equalizer #(
    parameter int MAX_BANDS    = 32,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cbe_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cbe_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cbe_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  cbe_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output cbe_pkg::result_t                result
);
    import cbe_pkg::*;

    localparam int BW     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HA_W   = BW + CW;
    localparam int CA_W   = BW + SEL_W;
    localparam int CLR_W  = (HA_W > CA_W) ? HA_W : CA_W;
    localparam int HDEPTH = 1 << HA_W;
    localparam int CDEPTH = 1 << CA_W;
    localparam logic [6:0] MAXB = 7'(MAX_BANDS);
    localparam logic [4:0] MAXC = 5'(MAX_CHANNELS);

    cfg_t     cfg;
    mac_ctl_t mac_ctl;
    logic signed [ACC_W-1:0]       acc;
    logic signed [COEF_BITS-1:0]   mac_a;
    logic signed [SAMPLE_BITS-1:0] mac_b;

    state_t state_reg, state_next;
    logic [BW-1:0]    band_reg, band_next;
    logic [BW-1:0]    last_band_reg, last_band_next;
    logic [SEL_W-1:0] k_reg, k_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_all_reg, clr_all_next;
    logic [2:0]       ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] d_reg, d_next;
    logic signed [SAMPLE_BITS-1:0] r_reg, r_next;

    logic    result_valid_reg;
    result_t result_reg;

    logic signed [COEF_BITS-1:0] coef_mem [CDEPTH];
    logic signed [COEF_BITS-1:0] coef_rdata_reg;
    logic                        coef_re;
    logic                        coef_we;
    logic [CA_W-1:0]             coef_raddr;
    logic [CA_W-1:0]             coef_waddr;
    logic signed [COEF_BITS-1:0] coef_wdata;
    logic [SEL_W-1:0]            coef_rsel;

    hist_row_t hist_mem [HDEPTH];
    hist_row_t hist_rdata_reg;
    hist_row_t hist_wdata;
    logic      hist_re;
    logic      hist_we;
    logic [HA_W-1:0] hist_addr;
    logic [HA_W-1:0] hist_waddr;

    logic       accept;
    logic       out_free;
    logic       load_out;
    logic       pass_out;
    logic       clr_done;
    logic       eq_sample;
    logic       bypass;
    logic       coef_wr_ok;
    logic [6:0] band_ext;
    logic [6:0] nb;
    logic [6:0] nb_m1;
    logic [4:0] ch_ext;
    logic [4:0] ch_in_ext;
    logic [4:0] nc;

    cbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbe_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (acc)
    );

    // Decode of the item at the input.
    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE) || (result_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    assign nb        = ({1'b0, cfg.bands_in_use} > MAXB) ? MAXB : {1'b0, cfg.bands_in_use};
    assign nc        = ({1'b0, cfg.channels_in_use} > MAXC) ? MAXC
                                                             : {1'b0, cfg.channels_in_use};
    assign nb_m1     = nb - 7'd1;
    assign ch_in_ext = {2'b00, item.channel};
    assign eq_sample = cfg.active && (nb != 7'd0) && (ch_in_ext < nc);
    assign band_ext  = {2'b00, item.band};
    assign coef_wr_ok = (band_ext < MAXB) && (item.coef_select <= SEL_BYPASS);
    assign ch_ext    = {2'b00, ch_reg};
    assign bypass    = coef_rdata_reg[0];
    assign pass_out  = (state_reg == S_IDLE) && accept && (item.mode == MODE_SAMPLE)
                       && !eq_sample;

    assign clr_done = clr_all_reg ? (&clr_cnt_reg) : (&clr_cnt_reg[HA_W-1:0]);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && (item.mode == MODE_SAMPLE) && eq_sample)
                begin
                    state_next = S_PRE_MUL;
                end
                else if (accept && (item.mode == MODE_FLUSH))
                begin
                    state_next = S_CLEAR;
                end
            end
            S_PRE_MUL:  state_next = S_PRE_ACC;
            S_PRE_ACC:  state_next = S_PRE_RND;
            S_PRE_RND:  state_next = S_BAND_RD;
            S_BAND_RD:  state_next = S_BAND_CHK;
            S_BAND_CHK: state_next = bypass ? S_WB : S_MAC;
            S_MAC:
            begin
                if (k_reg == SEL_A4)
                begin
                    state_next = S_MAC_END;
                end
            end
            S_MAC_END:  state_next = S_ROUND;
            S_ROUND:    state_next = S_WB;
            S_WB:       state_next = (band_reg == last_band_reg) ? S_DONE : S_BAND_RD;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        mac_ctl   = '0;
        coef_re   = 1'b0;
        coef_rsel = SEL_BYPASS;
        coef_we   = 1'b0;
        hist_re   = 1'b0;
        hist_we   = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                hist_we = 1'b1;
                coef_we = clr_all_reg;
            end
            S_IDLE:
            begin
                coef_we  = accept && (item.mode == MODE_COEF) && coef_wr_ok;
                load_out = pass_out;
            end
            S_PRE_MUL:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.clr    = 1'b1;
            end
            S_BAND_RD:
            begin
                hist_re   = 1'b1;
                coef_re   = 1'b1;
                coef_rsel = SEL_BYPASS;
            end
            S_BAND_CHK:
            begin
                coef_re   = 1'b1;
                coef_rsel = SEL_A0;
            end
            S_MAC:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.clr    = (k_reg == SEL_A0);
                mac_ctl.sub    = (k_reg == SEL_A3) || (k_reg == SEL_A4);
                coef_re        = (k_reg != SEL_A4);
                coef_rsel      = k_reg + 3'd1;
            end
            S_WB:
            begin
                hist_we = 1'b1;
            end
            S_DONE:
            begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // Operands of the shared multiplier.
    always_comb
    begin
        mac_a = coef_rdata_reg;
        mac_b = d_reg;
        if (state_reg == S_PRE_MUL)
        begin
            mac_a = $signed({{(COEF_BITS - GAIN_BITS){1'b0}}, cfg.preamp_gain});
        end
        else
        begin
            case (k_reg)
                SEL_A0:  mac_b = d_reg;
                SEL_A1:  mac_b = hist_rdata_reg.x1;
                SEL_A2:  mac_b = hist_rdata_reg.x2;
                SEL_A3:  mac_b = hist_rdata_reg.y1;
                SEL_A4:  mac_b = hist_rdata_reg.y2;
                default: mac_b = '0;
            endcase
        end
    end

    // Next values of the datapath and counters.
    always_comb
    begin
        band_next      = band_reg;
        last_band_next = last_band_reg;
        k_next         = k_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_all_next   = clr_all_reg;
        ch_next        = ch_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_done ? '0 : (clr_cnt_reg + 1'b1);
                if (clr_done)
                begin
                    clr_all_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    band_next      = '0;
                    last_band_next = nb_m1[BW-1:0];
                    ch_next        = item.channel;
                    d_next         = item.sample_in;
                end
            end
            S_PRE_RND:  d_next = round_sat(acc, 1'b1);
            S_BAND_CHK:
            begin
                k_next = SEL_A0;
                // A bypassed band hands its input on unchanged.
                r_next = d_reg;
            end
            S_MAC:      k_next = k_reg + 3'd1;
            S_ROUND:    r_next = round_sat(acc, 1'b0);
            S_WB:
            begin
                d_next    = r_reg;
                band_next = band_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            band_reg         <= '0;
            last_band_reg    <= '0;
            k_reg            <= SEL_A0;
            clr_cnt_reg      <= '0;
            clr_all_reg      <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            last_band_reg <= last_band_next;
            k_reg         <= k_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_all_reg   <= clr_all_next;
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
        d_reg  <= d_next;
        r_reg  <= r_next;
        if (load_out)
        begin
            if (pass_out)
            begin
                result_reg.out_channel <= item.channel;
                result_reg.sample_out  <= item.sample_in;
            end
            else
            begin
                result_reg.out_channel <= ch_reg;
                result_reg.sample_out  <= d_reg;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Coefficient memory: each band owns eight slots, the bypass flag in one.
    assign coef_raddr = {band_reg, coef_rsel};

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            coef_waddr = clr_cnt_reg[CA_W-1:0];
            coef_wdata = (clr_cnt_reg[SEL_W-1:0] == SEL_BYPASS) ? COEF_BITS'(1) : '0;
        end
        else
        begin
            coef_waddr = {band_ext[BW-1:0], item.coef_select};
            coef_wdata = (item.coef_select == SEL_BYPASS)
                         ? $signed({{(COEF_BITS - 1){1'b0}}, item.coef_value[0]})
                         : item.coef_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (coef_re)
        begin
            coef_rdata_reg <= coef_mem[coef_raddr];
        end
    end

    // History memory: one row holds x1, x2, y1 and y2 of a band and channel.
    assign hist_addr  = {band_reg, ch_ext[CW-1:0]};
    assign hist_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg[HA_W-1:0] : hist_addr;

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            hist_wdata = '0;
        end
        else
        begin
            hist_wdata.x1 = d_reg;
            hist_wdata.x2 = hist_rdata_reg.x1;
            hist_wdata.y1 = r_reg;
            hist_wdata.y2 = hist_rdata_reg.y1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_addr];
        end
    end

endmodule
